// ===== rtl/core/bfsa_pkg.sv =====
// Shared types and constants for the best-fit segment allocator.
// No dependencies.
package bfsa_pkg;
  localparam int MaxSeg   = 16;
  localparam int SegIdxW  = $clog2(MaxSeg);
  localparam int SegCntW  = $clog2(MaxSeg + 1);
  localparam int MemUnits = 1024;
  localparam int LenW     = 11;
  localparam int PidW     = 8;
  localparam int AddrW    = 10;
  localparam int StatW    = 3;
  localparam int QDepth   = 2;

  localparam logic [StatW-1:0] ST_OK         = 3'd0;
  localparam logic [StatW-1:0] ST_OK_COMPACT = 3'd1;
  localparam logic [StatW-1:0] ST_NOFIT      = 3'd2;
  localparam logic [StatW-1:0] ST_FULL       = 3'd3;
  localparam logic [StatW-1:0] ST_FREED      = 3'd4;

  typedef enum logic [1:0] {CMD_ALLOC, CMD_FREE, CMD_ZERO} cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [PidW-1:0]  pid;
    logic [LenW-1:0]  need;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FREE, S_MERGE, S_MSHIFT, S_SCAN, S_COMPACT, S_CTOP,
    S_GRANT, S_SPLIT, S_SSHIFT, S_OUT
  } bk_state_t;
endpackage

// ===== rtl/core/bfsa_front.sv =====
// Front end: accepts items, classifies them and queues commands.
// Depends on bfsa_pkg.
module bfsa_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic           in_tuser,   // action
  input  logic [23:0]    in_tdata,   // pid[7:0], request_size[18:8], zero pad
  input  logic           flush,
  output logic           q_valid,
  output bfsa_pkg::cmd_t q_cmd,
  input  logic           q_pop
);
  import bfsa_pkg::*;
  cmd_t q_r [QDepth];
  logic [$clog2(QDepth)-1:0] wp_r, rp_r;
  logic [$clog2(QDepth+1)-1:0] cnt_r;
  cmd_t c;
  logic push, pop;

  // classify the incoming item
  always_comb begin
    c.pid  = in_tdata[PidW-1:0];
    c.need = in_tdata[PidW+LenW-1:PidW];
    if (in_tuser) c.kind = CMD_FREE;
    else if (c.need == '0) c.kind = CMD_ZERO;
    else c.kind = CMD_ALLOC;
  end

  assign in_tready = (cnt_r != QDepth[$clog2(QDepth+1)-1:0]);
  assign push = in_tvalid && in_tready;
  assign pop = q_pop && q_valid;
  assign q_valid = (cnt_r != '0);
  assign q_cmd = q_r[rp_r];

  // queue storage and pointers
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= c;
    if (!rst_n || flush) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {{($clog2(QDepth+1)-1){1'b0}}, push}
                     - {{($clog2(QDepth+1)-1){1'b0}}, pop};
    end
  end
endmodule

// ===== rtl/core/bfsa_back.sv =====
// Back end: walks the segment table one entry per cycle to free, merge,
// search, compact and split. Depends on bfsa_pkg.
module bfsa_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [10:0]               cfg_wr_data,
  input  logic                      q_valid,
  input  bfsa_pkg::cmd_t            q_cmd,
  output logic                      q_pop,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [15:0]               out_tdata  // status[2:0], grant_addr[12:3], pad
);
  import bfsa_pkg::*;
  logic [LenW-1:0] st_r [MaxSeg];
  logic [LenW-1:0] ln_r [MaxSeg];
  logic [MaxSeg-1:0] us_r;
  logic [PidW-1:0] ow_r [MaxSeg];
  logic [SegCntW-1:0] cnt_r;
  logic [LenW-1:0] msize_r;
  bk_state_t s_r, s_nxt;
  cmd_t cmd_r;
  logic [SegCntW-1:0] i_r, k_r, n_r;
  logic [LenW-1:0] pos_r, slack_r;
  logic best_v_r, compacted_r;
  logic [SegIdxW-1:0] best_r;
  logic [StatW-1:0] stat_r;
  logic [AddrW-1:0] addr_r;
  logic [LenW-1:0] clamp;
  logic [SegIdxW-1:0] ii, kk, nn, bi;
  logic fits;
  logic [LenW-1:0] sl;

  assign ii = i_r[SegIdxW-1:0];
  assign kk = k_r[SegIdxW-1:0];
  assign nn = n_r[SegIdxW-1:0];
  assign bi = best_r;
  assign fits = !us_r[ii] && ln_r[ii] >= cmd_r.need;
  assign sl = ln_r[ii] - cmd_r.need;
  assign q_pop = (s_r == S_IDLE) && q_valid;
  assign out_tvalid = (s_r == S_OUT);
  assign out_tdata = {3'b000, addr_r, stat_r};

  // clamp a written size into range
  always_comb begin
    if (cfg_wr_data == '0) clamp = LenW'(1);
    else if (cfg_wr_data > LenW'(MemUnits)) clamp = LenW'(MemUnits);
    else clamp = cfg_wr_data;
  end

  // next state
  always_comb begin
    s_nxt = s_r;
    case (s_r)
      S_IDLE: if (q_valid) begin
        case (q_cmd.kind)
          CMD_FREE: s_nxt = S_FREE;
          CMD_ALLOC: s_nxt = S_SCAN;
          default: s_nxt = S_OUT;
        endcase
      end
      S_FREE: if (i_r + 1'b1 >= cnt_r) s_nxt = S_MERGE;
      S_MERGE: begin
        if (i_r + 1'b1 >= cnt_r) s_nxt = S_OUT;
        else if (!us_r[ii] && !us_r[ii+1'b1]) s_nxt = S_MSHIFT;
      end
      S_MSHIFT: if (k_r + 1'b1 >= cnt_r) s_nxt = S_MERGE;
      S_SCAN: if (i_r + 1'b1 >= cnt_r) begin
        if (best_v_r || fits) s_nxt = S_GRANT;
        else if (compacted_r) s_nxt = S_OUT;
        else s_nxt = S_COMPACT;
      end
      S_COMPACT: if (i_r + 1'b1 >= cnt_r) s_nxt = S_CTOP;
      S_CTOP: s_nxt = S_SCAN;
      S_GRANT: begin
        if (ln_r[bi] == cmd_r.need) s_nxt = S_OUT;
        else if (cnt_r >= SegCntW'(MaxSeg)) s_nxt = S_OUT;
        else s_nxt = S_SSHIFT;
      end
      S_SSHIFT: if (k_r <= {1'b0, best_r} + 2'd1) s_nxt = S_SPLIT;
      S_SPLIT: s_nxt = S_OUT;
      S_OUT: if (out_tready) s_nxt = S_IDLE;
      default: s_nxt = S_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr_en) begin
      s_r <= S_IDLE;
      us_r <= '0;
      cnt_r <= SegCntW'(1);
      st_r[0] <= '0;
      ln_r[0] <= rst_n ? clamp : LenW'(MemUnits);
      if (!rst_n) msize_r <= LenW'(MemUnits);
      else msize_r <= clamp;
    end else begin
      s_r <= s_nxt;
      case (s_r)
        S_IDLE: begin
          cmd_r <= q_cmd;
          i_r <= '0; best_v_r <= 1'b0; compacted_r <= 1'b0;
          addr_r <= '0;
          stat_r <= (q_cmd.kind == CMD_FREE) ? ST_FREED : ST_FULL;
        end
        S_FREE: begin
          if (us_r[ii] && ow_r[ii] == cmd_r.pid) us_r[ii] <= 1'b0;
          i_r <= (i_r + 1'b1 >= cnt_r) ? '0 : i_r + 1'b1;
        end
        S_MERGE: begin
          if (i_r + 1'b1 < cnt_r) begin
            if (!us_r[ii] && !us_r[ii+1'b1]) begin
              ln_r[ii] <= ln_r[ii] + ln_r[ii+1'b1];
              k_r <= i_r + 1'b1;
            end else i_r <= i_r + 1'b1;
          end
        end
        S_MSHIFT: begin
          if (k_r + 1'b1 < cnt_r) begin
            st_r[kk] <= st_r[kk+1'b1]; ln_r[kk] <= ln_r[kk+1'b1];
            us_r[kk] <= us_r[kk+1'b1]; ow_r[kk] <= ow_r[kk+1'b1];
            k_r <= k_r + 1'b1;
          end else cnt_r <= cnt_r - 1'b1;
        end
        S_SCAN: begin
          if (fits && (!best_v_r || sl < slack_r)) begin
            best_v_r <= 1'b1; best_r <= ii; slack_r <= sl;
          end
          if (i_r + 1'b1 >= cnt_r) begin
            i_r <= '0; n_r <= '0; pos_r <= '0;
            if (!(best_v_r || fits)) stat_r <= compacted_r ? ST_NOFIT : ST_OK_COMPACT;
            else stat_r <= compacted_r ? ST_OK_COMPACT : ST_OK;
          end else i_r <= i_r + 1'b1;
        end
        S_COMPACT: begin
          if (us_r[ii]) begin
            st_r[nn] <= pos_r; ln_r[nn] <= ln_r[ii];
            us_r[nn] <= 1'b1; ow_r[nn] <= ow_r[ii];
            pos_r <= pos_r + ln_r[ii];
            n_r <= n_r + 1'b1;
          end
          i_r <= i_r + 1'b1;
        end
        S_CTOP: begin
          compacted_r <= 1'b1; i_r <= '0;
          if (pos_r < msize_r && n_r < SegCntW'(MaxSeg)) begin
            st_r[nn] <= pos_r; ln_r[nn] <= msize_r - pos_r; us_r[nn] <= 1'b0;
            cnt_r <= n_r + 1'b1;
          end else cnt_r <= n_r;
        end
        S_GRANT: begin
          k_r <= cnt_r;
          if (ln_r[bi] == cmd_r.need) begin
            us_r[bi] <= 1'b1; ow_r[bi] <= cmd_r.pid;
            addr_r <= st_r[bi][AddrW-1:0];
          end else if (cnt_r >= SegCntW'(MaxSeg)) stat_r <= ST_FULL;
        end
        S_SSHIFT: begin
          if (k_r > {1'b0, best_r} + 2'd1) begin
            st_r[kk] <= st_r[kk-1'b1]; ln_r[kk] <= ln_r[kk-1'b1];
            us_r[kk] <= us_r[kk-1'b1]; ow_r[kk] <= ow_r[kk-1'b1];
            k_r <= k_r - 1'b1;
          end
        end
        S_SPLIT: begin
          st_r[bi+1'b1] <= st_r[bi] + cmd_r.need;
          ln_r[bi+1'b1] <= ln_r[bi] - cmd_r.need;
          us_r[bi+1'b1] <= 1'b0;
          ln_r[bi] <= cmd_r.need;
          us_r[bi] <= 1'b1; ow_r[bi] <= cmd_r.pid;
          addr_r <= st_r[bi][AddrW-1:0];
          cnt_r <= cnt_r + 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/core/best_fit_segment_allocator_core.sv =====
// Best-fit segment allocator top level: front queue plus table engine.
// Depends on bfsa_pkg, bfsa_front, bfsa_back.
//
// Usage: send requests on in_* (tuser = action, 1 frees a pid; tdata =
// pid and request_size). Each item yields one result on out_* with the
// status and granted start address. A two-entry command queue sits between
// the front end and the table engine, so up to two items are taken while
// the engine works or the receiver stalls. The engine visits one table
// entry per cycle and works on one item at a time. An allocate costs one
// scan, plus on no fit a compaction pass, a top-hole step and a rescan,
// plus a shift of up to 14 entries on a split. A free costs a release
// pass and a merge walk in which every merge shifts the tail down one
// entry. A result holds on out_* until out_tready. Reset (rst_n low,
// synchronous) and any cfg_wr_en write reset the table to one free hole
// and drop queued items; the register clamps to 1..1024.
module best_fit_segment_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,   // action
  input  logic [23:0] in_tdata,   // pid[7:0], request_size[18:8], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // status[2:0], grant_addr[12:3], zero pad
);
  import bfsa_pkg::*;
  logic q_valid, q_pop;
  cmd_t q_cmd;

  bfsa_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tuser, .in_tdata,
    .flush(cfg_wr_en), .q_valid, .q_cmd, .q_pop
  );

  bfsa_back u_back (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data, .q_valid, .q_cmd, .q_pop,
    .out_tvalid, .out_tready, .out_tdata
  );
endmodule
